// ===== rtl/nrp_pkg.sv =====
// ----------------------------------------------------------------------------
// nrp_pkg: shared types and constants of the nested region profiler
// Beat payloads, operation and status codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package nrp_pkg;

   localparam int unsigned SLOTS_DEFAULT     = 32;
   localparam int unsigned KEY_BITS_DEFAULT  = 16;
   localparam int unsigned TIME_BITS_DEFAULT = 32;

   localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_END   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_FULL    = 3'd1;
   localparam logic [2:0] STAT_UNKNOWN = 3'd2;
   localparam logic [2:0] STAT_OPEN    = 3'd3;
   localparam logic [2:0] STAT_OVER    = 3'd4;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] region_id;
      logic [4:0]  slot_index;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        slot_valid;
      logic [15:0] slot_region;
      logic [31:0] frame_elapsed;
      logic [47:0] accum_time;
      logic [47:0] self_time;
      logic [31:0] instance_count;
      logic [5:0]  nest_depth;
      logic [31:0] avg_time;
      logic [31:0] shortest_time;
      logic [31:0] longest_time;
      logic [31:0] end_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_FOUND,
      S_MISS,
      S_PSCAN,
      S_EUPD,
      S_PWR,
      S_RDW,
      S_REPORT,
      S_DIV,
      S_OUT
   } state_type;

endpackage

// ===== rtl/nested_region_profiler_core.sv =====
// ----------------------------------------------------------------------------
// nested_region_profiler_core: profiling region table with nesting
// Sequencer around a single-port-read region table and an iterative divider.
// ----------------------------------------------------------------------------
// Usage: events enter on the req_ channel (valid/ready), one beat per event:
// begin, end, read slot or clear, each stamped with the current timer value.
// Every event yields exactly one rsp_ beat with the status, the elapsed frame
// time and the statistics of the slot that the event touched.
// Sequencing: one event is in work at a time. Begin and end search the
// occupied slots one table read per cycle; end then scans the occupied
// slots again for the depth and the parent and updates up to two entries.
// Any report of a slot with completed ends runs the divider for the
// average. A clear goes from idle straight to the output state.
// The next request is taken as soon as the previous result sits in the
// response register, even while the receiver stalls it; a second result
// waits in the sequencer until the register drains.
// Reset empties the table and zeroes the frame start; the block is ready
// when reset falls, with no clearing pass.
// ----------------------------------------------------------------------------
module nested_region_profiler_core #(
   parameter int unsigned SLOTS     = nrp_pkg::SLOTS_DEFAULT,
   parameter int unsigned KEY_BITS  = nrp_pkg::KEY_BITS_DEFAULT,
   parameter int unsigned TIME_BITS = nrp_pkg::TIME_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nrp_pkg::rsp_type rsp_data
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned KW = KEY_BITS;
   localparam int unsigned TW = TIME_BITS;
   localparam int unsigned SW = ((TW > 48) ? TW : 48) + 1;

   typedef struct packed {
      logic [KW-1:0] key;
      logic [7:0]    oc;
      logic [31:0]   inst;
      logic [TW-1:0] start;
      logic [47:0]   acc;
      logic [47:0]   child;
      logic [5:0]    depth;
      logic [31:0]   calls;
      logic [TW-1:0] shortest;
      logic [TW-1:0] longest;
   } entry_type;

   localparam int unsigned EW = $bits(entry_type);

   function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [TW-1:0] b);
      logic [SW-1:0] s;
      s = SW'(a) + SW'(b);
      return (s > SW'(nrp_pkg::SAT48)) ? nrp_pkg::SAT48 : s[47:0];
   endfunction

   nrp_pkg::state_type state_ff, state_in;

   logic [1:0]    op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [TW-1:0] ts_ff, ts_in;
   logic [TW-1:0] frame_ff, frame_in;
   logic [31:0]   fe_ff, fe_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pidx_ff, pidx_in;
   logic [IW-1:0] slot_ff, slot_in;
   entry_type     ent_ff, ent_in;
   logic [TW-1:0] tm_ff, tm_in;
   logic [5:0]    depth_ff, depth_in;
   logic          par_vld_ff, par_vld_in;
   logic [IW-1:0] par_ff, par_in;
   logic [TW-1:0] par_stamp_ff, par_stamp_in;
   logic [2:0]    status_ff, status_in;
   logic          has_slot_ff, has_slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   nrp_pkg::rsp_type rsp_ff, rsp_in;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data;
   entry_type     wr_ent, rd_ent;
   logic          div_start, div_done;
   logic [47:0]   div_quo;
   logic [TW-1:0] req_ts;

   assign rd_ent = entry_type'(rd_data);
   assign req_ts = TW'(req_data.timestamp);

   nrp_ram #(
      .DEPTH (SLOTS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nrp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ent_ff.acc),
      .divisor  (ent_ff.calls),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nrp_pkg::S_IDLE;
         fill_ff      <= '0;
         frame_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         frame_ff     <= frame_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      key_ff       <= key_in;
      ts_ff        <= ts_in;
      fe_ff        <= fe_in;
      cnt_ff       <= cnt_in;
      pidx_ff      <= pidx_in;
      slot_ff      <= slot_in;
      ent_ff       <= ent_in;
      tm_ff        <= tm_in;
      depth_ff     <= depth_in;
      par_vld_ff   <= par_vld_in;
      par_ff       <= par_in;
      par_stamp_ff <= par_stamp_in;
      status_ff    <= status_in;
      has_slot_ff  <= has_slot_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      entry_type        e;
      entry_type        d;
      nrp_pkg::rsp_type r;
      logic [47:0]      q;

      e = ent_ff;
      d = rd_ent;
      r = '0;
      q = div_quo;

      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      ts_in        = ts_ff;
      frame_in     = frame_ff;
      fe_in        = fe_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      slot_in      = slot_ff;
      ent_in       = ent_ff;
      tm_in        = tm_ff;
      depth_in     = depth_ff;
      par_vld_in   = par_vld_ff;
      par_in       = par_ff;
      par_stamp_in = par_stamp_ff;
      status_in    = status_ff;
      has_slot_in  = has_slot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_ent       = ent_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         nrp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_data.opcode;
               key_in      = KW'(req_data.region_id);
               ts_in       = req_ts;
               fe_in       = 32'(TW'(req_ts - frame_ff));
               has_slot_in = 1'b0;
               status_in   = nrp_pkg::STAT_OK;
               cnt_in      = '0;
               pend_in     = 1'b0;
               unique case (req_data.opcode) inside
                  nrp_pkg::OP_BEGIN, nrp_pkg::OP_END: begin
                     state_in = nrp_pkg::S_SCAN;
                  end
                  nrp_pkg::OP_READ: begin
                     if (9'(req_data.slot_index) < 9'(fill_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = IW'(req_data.slot_index);
                        state_in = nrp_pkg::S_RDW;
                     end else begin
                        state_in = nrp_pkg::S_OUT;
                     end
                  end
                  default: begin
                     fill_in  = '0;
                     frame_in = req_ts;
                     state_in = nrp_pkg::S_OUT;
                  end
               endcase
            end
         end

         // Key search over the occupied slots, one read issued per cycle.
         nrp_pkg::S_SCAN: begin
            if (pend_ff && rd_ent.key == key_ff) begin
               ent_in   = rd_ent;
               slot_in  = pidx_ff;
               pend_in  = 1'b0;
               state_in = nrp_pkg::S_FOUND;
            end else if (cnt_ff < fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = IW'(cnt_ff);
               pidx_in = IW'(cnt_ff);
               cnt_in  = CW'(cnt_ff + 1'b1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = nrp_pkg::S_MISS;
               end
            end
         end

         nrp_pkg::S_FOUND: begin
            if (op_ff == nrp_pkg::OP_BEGIN) begin
               if (e.oc != 8'h7F) begin
                  e.oc = 8'(e.oc + 8'd1);
               end
               if (e.inst != nrp_pkg::SAT32) begin
                  e.inst = 32'(e.inst + 32'd1);
               end
               e.start     = ts_ff;
               wr_en       = 1'b1;
               wr_addr     = slot_ff;
               wr_ent      = e;
               ent_in      = e;
               has_slot_in = 1'b1;
               // Open count above one after the begin means re-entry.
               status_in   = (!e.oc[7] && e.oc > 8'd1) ? nrp_pkg::STAT_OPEN
                                                       : nrp_pkg::STAT_OK;
               state_in    = nrp_pkg::S_REPORT;
            end else begin
               if (e.oc != 8'h80) begin
                  e.oc = 8'(e.oc - 8'd1);
               end
               tm_in      = TW'(ts_ff - ent_ff.start);
               ent_in     = e;
               cnt_in     = '0;
               pend_in    = 1'b0;
               depth_in   = '0;
               par_vld_in = 1'b0;
               state_in   = nrp_pkg::S_PSCAN;
            end
         end

         nrp_pkg::S_MISS: begin
            if (op_ff == nrp_pkg::OP_END) begin
               status_in = nrp_pkg::STAT_UNKNOWN;
               state_in  = nrp_pkg::S_OUT;
            end else if (fill_ff == CW'(SLOTS)) begin
               status_in = nrp_pkg::STAT_FULL;
               state_in  = nrp_pkg::S_OUT;
            end else begin
               e           = '0;
               e.key       = key_ff;
               e.oc        = 8'd1;
               e.inst      = 32'd1;
               e.start     = ts_ff;
               wr_en       = 1'b1;
               wr_addr     = IW'(fill_ff);
               wr_ent      = e;
               ent_in      = e;
               slot_in     = IW'(fill_ff);
               fill_in     = CW'(fill_ff + 1'b1);
               has_slot_in = 1'b1;
               state_in    = nrp_pkg::S_REPORT;
            end
         end

         // Depth count and parent search; the ended slot's open count comes
         // from the working copy, as the table still holds the old one.
         nrp_pkg::S_PSCAN: begin
            if (pend_ff) begin
               if (pidx_ff == slot_ff) begin
                  d.oc = ent_ff.oc;
               end
               if (!d.oc[7] && d.oc != 8'd0) begin
                  if (depth_ff != 6'h3F) begin
                     depth_in = 6'(depth_ff + 6'd1);
                  end
                  if (!par_vld_ff || d.start >= par_stamp_ff) begin
                     par_vld_in   = 1'b1;
                     par_in       = pidx_ff;
                     par_stamp_in = d.start;
                  end
               end
            end
            if (cnt_ff < fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = IW'(cnt_ff);
               pidx_in = IW'(cnt_ff);
               cnt_in  = CW'(cnt_ff + 1'b1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = nrp_pkg::S_EUPD;
               end
            end
         end

         nrp_pkg::S_EUPD: begin
            e.depth = depth_ff;
            e.acc   = sat_add(e.acc, tm_ff);
            if (e.calls == 32'd0) begin
               e.calls    = 32'd1;
               e.shortest = tm_ff;
               e.longest  = tm_ff;
            end else begin
               if (e.calls != nrp_pkg::SAT32) begin
                  e.calls = 32'(e.calls + 32'd1);
               end
               if (tm_ff < e.shortest) begin
                  e.shortest = tm_ff;
               end
               if (tm_ff > e.longest) begin
                  e.longest = tm_ff;
               end
            end
            if (par_vld_ff && par_ff == slot_ff) begin
               e.child = sat_add(e.child, tm_ff);
            end
            wr_en       = 1'b1;
            wr_addr     = slot_ff;
            wr_ent      = e;
            ent_in      = e;
            has_slot_in = 1'b1;
            status_in   = e.oc[7] ? nrp_pkg::STAT_OVER : nrp_pkg::STAT_OK;
            if (par_vld_ff && par_ff != slot_ff) begin
               rd_en    = 1'b1;
               rd_addr  = par_ff;
               state_in = nrp_pkg::S_PWR;
            end else begin
               state_in = nrp_pkg::S_REPORT;
            end
         end

         nrp_pkg::S_PWR: begin
            d.child  = sat_add(d.child, tm_ff);
            wr_en    = 1'b1;
            wr_addr  = par_ff;
            wr_ent   = d;
            state_in = nrp_pkg::S_REPORT;
         end

         nrp_pkg::S_RDW: begin
            ent_in      = rd_ent;
            has_slot_in = 1'b1;
            if (rd_ent.oc[7]) begin
               status_in = nrp_pkg::STAT_OVER;
            end else if (rd_ent.oc != 8'd0) begin
               status_in = nrp_pkg::STAT_OPEN;
            end else begin
               status_in = nrp_pkg::STAT_OK;
            end
            state_in = nrp_pkg::S_REPORT;
         end

         nrp_pkg::S_REPORT: begin
            if (ent_ff.calls == 32'd0) begin
               state_in = nrp_pkg::S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = nrp_pkg::S_DIV;
            end
         end

         nrp_pkg::S_DIV: begin
            if (div_done) begin
               state_in = nrp_pkg::S_OUT;
            end
         end

         nrp_pkg::S_OUT: begin
            r.status        = status_ff;
            r.frame_elapsed = fe_ff;
            if (has_slot_ff) begin
               r.slot_valid     = 1'b1;
               r.slot_region    = 16'(ent_ff.key);
               r.accum_time     = ent_ff.acc;
               r.self_time      = (ent_ff.acc >= ent_ff.child) ?
                                  48'(ent_ff.acc - ent_ff.child) : 48'd0;
               r.instance_count = ent_ff.inst;
               r.nest_depth     = ent_ff.depth;
               if (ent_ff.calls != 32'd0) begin
                  r.avg_time = (q[47:32] != 16'd0) ? nrp_pkg::SAT32 : q[31:0];
               end
               r.shortest_time  = 32'(ent_ff.shortest);
               r.longest_time   = 32'(ent_ff.longest);
               r.end_count      = ent_ff.calls;
            end
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = r;
               state_in     = nrp_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = nrp_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/nrp_ram.sv =====
// ----------------------------------------------------------------------------
// nrp_ram: region table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nrp_ram #(
   parameter int unsigned DEPTH = nrp_pkg::SLOTS_DEFAULT,
   parameter int unsigned WIDTH = 8,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nrp_div.sv =====
// ----------------------------------------------------------------------------
// nrp_div: iterative unsigned divider for the average time
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [47:0] quotient
);

   localparam logic [5:0] LAST_STEP = 6'd47;

   logic [47:0] work_ff, work_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic        fits;

   always_comb begin
      trial   = {rem_ff, work_ff[47]};
      fits    = trial >= {1'b0, dsr_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so 32 bits hold it.
         rem_in  = fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
         work_in = {work_ff[46:0], fits};
         cnt_in  = 6'(cnt_ff + 6'd1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ===== dv/tb_nested_region_profiler_core.sv =====
// ----------------------------------------------------------------------------
// tb_nested_region_profiler_core: self-checking bench of the region profiler
// Drives begin, end, read and clear beats with random gaps, predicts every
// response beat with an in-bench model of the region table, and compares
// the response beats in order, each whole beat against its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nested_region_profiler_core;

   localparam int NSLOT = 32;
   localparam longint CYCLE_LIMIT = 2000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   nrp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   nrp_pkg::rsp_type rsp_data;

   nested_region_profiler_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Predicted table state.
   bit          tbl_valid [NSLOT];
   logic [15:0] tbl_key   [NSLOT];
   int          tbl_open  [NSLOT];
   logic [31:0] tbl_inst  [NSLOT];
   logic [31:0] tbl_start [NSLOT];
   logic [47:0] tbl_acc   [NSLOT];
   logic [47:0] tbl_child [NSLOT];
   logic [5:0]  tbl_depth [NSLOT];
   logic [31:0] tbl_calls [NSLOT];
   logic [31:0] tbl_min   [NSLOT];
   logic [31:0] tbl_max   [NSLOT];
   logic [31:0] frame_t0;

   nrp_pkg::rsp_type expected_rsp[$];
   int      mismatches = 0;
   longint  cycles = 0;
   bit      quiet_rx = 1'b0;
   int      hold_cycles = 0;
   logic [15:0] keys_live[$];

   function automatic logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[48] ? nrp_pkg::SAT48 : s[47:0];
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 0; tbl_depth[i] = '0; tbl_calls[i] = '0;
         tbl_min[i] = '0; tbl_max[i] = '0;
      end
   endfunction

   function automatic void fill_stats(ref nrp_pkg::rsp_type r, input int s);
      logic [47:0] avg;
      r.slot_valid = 1'b1;
      r.slot_region = tbl_key[s];
      r.accum_time = tbl_acc[s];
      r.self_time = (tbl_acc[s] >= tbl_child[s]) ? tbl_acc[s] - tbl_child[s] : '0;
      r.instance_count = tbl_inst[s];
      r.nest_depth = tbl_depth[s];
      avg = (tbl_calls[s] != 0) ? tbl_acc[s] / tbl_calls[s] : '0;
      r.avg_time = (avg > {16'd0, nrp_pkg::SAT32}) ? nrp_pkg::SAT32 : avg[31:0];
      r.shortest_time = tbl_min[s];
      r.longest_time = tbl_max[s];
      r.end_count = tbl_calls[s];
   endfunction

   function automatic int lookup_slot(logic [15:0] key, output bit hit);
      int i = 0;
      hit = 0;
      while (i < NSLOT && tbl_valid[i]) begin
         if (tbl_key[i] == key) begin
            hit = 1;
            return i;
         end
         i++;
      end
      return i;
   endfunction

   function automatic nrp_pkg::rsp_type profile_event(nrp_pkg::req_type q);
      nrp_pkg::rsp_type r;
      bit hit;
      int s, parent, depth;
      logic [31:0] tm;
      r = '0;
      r.frame_elapsed = q.timestamp - frame_t0;
      case (q.opcode)
         nrp_pkg::OP_BEGIN: begin
            s = lookup_slot(q.region_id, hit);
            if (hit) begin
               if (tbl_open[s] < 127) tbl_open[s]++;
               if (tbl_inst[s] != nrp_pkg::SAT32) tbl_inst[s]++;
               tbl_start[s] = q.timestamp;
               if (tbl_open[s] > 1) r.status = nrp_pkg::STAT_OPEN;
               fill_stats(r, s);
            end else if (s >= NSLOT) begin
               r.status = nrp_pkg::STAT_FULL;
            end else begin
               tbl_valid[s] = 1; tbl_key[s] = q.region_id; tbl_open[s] = 1;
               tbl_inst[s] = 1; tbl_acc[s] = '0; tbl_start[s] = q.timestamp;
               tbl_child[s] = '0; tbl_depth[s] = '0; tbl_calls[s] = '0;
               tbl_min[s] = '0; tbl_max[s] = '0;
               fill_stats(r, s);
            end
         end
         nrp_pkg::OP_END: begin
            s = lookup_slot(q.region_id, hit);
            if (!hit) begin
               r.status = nrp_pkg::STAT_UNKNOWN;
            end else begin
               if (tbl_open[s] > -128) tbl_open[s]--;
               tm = q.timestamp - tbl_start[s];
               depth = 0;
               parent = NSLOT;
               for (int j = 0; j < NSLOT && tbl_valid[j]; j++) begin
                  if (tbl_open[j] > 0) begin
                     depth++;
                     if (parent >= NSLOT || tbl_start[j] >= tbl_start[parent]) parent = j;
                  end
               end
               tbl_depth[s] = (depth > 63) ? 6'd63 : depth[5:0];
               if (parent < NSLOT) tbl_child[parent] = sat_add48(tbl_child[parent], tm);
               tbl_acc[s] = sat_add48(tbl_acc[s], tm);
               if (tbl_calls[s] == 0) begin
                  tbl_calls[s] = 1; tbl_min[s] = tm; tbl_max[s] = tm;
               end else begin
                  if (tbl_calls[s] != nrp_pkg::SAT32) tbl_calls[s]++;
                  if (tm < tbl_min[s]) tbl_min[s] = tm;
                  if (tm > tbl_max[s]) tbl_max[s] = tm;
               end
               if (tbl_open[s] < 0) r.status = nrp_pkg::STAT_OVER;
               fill_stats(r, s);
            end
         end
         nrp_pkg::OP_READ: begin
            s = q.slot_index;
            if (tbl_valid[s]) begin
               if (tbl_open[s] > 0) r.status = nrp_pkg::STAT_OPEN;
               else if (tbl_open[s] < 0) r.status = nrp_pkg::STAT_OVER;
               fill_stats(r, s);
            end
         end
         default: begin
            wipe_table();
            frame_t0 = q.timestamp;
         end
      endcase
      return r;
   endfunction

   // Sender: one beat, with an optional random gap before it.
   bit quiet_tx = 1'b0;

   task automatic send_event(input logic [1:0] op, input logic [15:0] key,
                             input logic [4:0] idx, input logic [31:0] ts);
      nrp_pkg::req_type q;
      q.opcode = op; q.region_id = key; q.slot_index = idx; q.timestamp = ts;
      while (!quiet_tx && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(profile_event(q));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Receiver readiness.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 17);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      nrp_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   function automatic logic [31:0] rand_ts();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return nrp_pkg::SAT32;
         default: return $urandom;
      endcase
   endfunction

   logic [31:0] clock_ts = 0;

   task automatic test_directed();
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd0, 32'd5);
      send_event(nrp_pkg::OP_END, 16'hFFFF, 5'd31, 32'd7);
      send_event(nrp_pkg::OP_BEGIN, 16'h0000, 5'd0, 32'hFFFF_FFF0);
      send_event(nrp_pkg::OP_BEGIN, 16'hFFFF, 5'd31, 32'hFFFF_FFF8);
      send_event(nrp_pkg::OP_BEGIN, 16'hFFFF, 5'd0, 32'd3);    // still open
      send_event(nrp_pkg::OP_END, 16'hFFFF, 5'd0, 32'd20);     // one open remains
      send_event(nrp_pkg::OP_END, 16'h0000, 5'd0, 32'd40);
      send_event(nrp_pkg::OP_END, 16'h0000, 5'd0, 32'd50);     // over-closed
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd0, 32'd60);
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd1, 32'd61);
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd31, 32'd62);
      send_event(nrp_pkg::OP_CLEAR, 16'h0, 5'd0, 32'hFFFF_FFFF);
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd0, 32'd1);
      for (int i = 0; i < 33; i++)                            // last one finds the table full
         send_event(nrp_pkg::OP_BEGIN, 16'(i * 2047), 5'(i), 32'(i * 3));
      send_event(nrp_pkg::OP_END, 16'd0, 5'd0, 32'd500);
      send_event(nrp_pkg::OP_READ, 16'h0, 5'd31, 32'd600);
      send_event(nrp_pkg::OP_CLEAR, 16'h0, 5'd0, 32'd0);
   endtask

   // Mostly balanced nested begin/end sequences on a small key set.
   task automatic test_random(input int count);
      logic [15:0] k;
      int pick;
      for (int n = 0; n < count; n++) begin
         clock_ts = clock_ts + $urandom_range(2000);
         pick = $urandom_range(99);
         if (pick < 40) begin
            k = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(11));
            keys_live.push_back(k);
            send_event(nrp_pkg::OP_BEGIN, k, 5'($urandom), clock_ts);
         end else if (pick < 75) begin
            k = (keys_live.size() != 0 && $urandom_range(7) != 0)
                ? keys_live.pop_back() : 16'($urandom_range(15));
            send_event(nrp_pkg::OP_END, k, 5'($urandom), clock_ts);
         end else if (pick < 95) begin
            send_event(nrp_pkg::OP_READ, 16'($urandom), 5'($urandom), clock_ts);
         end else if (pick < 97) begin
            keys_live.delete();
            send_event(nrp_pkg::OP_CLEAR, 16'($urandom), 5'($urandom), clock_ts);
         end else begin
            send_event(nrp_pkg::OP_BEGIN, 16'($urandom), 5'($urandom), rand_ts());
         end
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 2000;
      quiet_tx = 1'b1;
      test_random(40);
      quiet_tx = 1'b0;
      drain_results();
      test_random(30);
   endtask

   task automatic test_no_idle();
      quiet_tx = 1'b1;
      quiet_rx = 1'b1;
      test_random(150);
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
   endtask

   initial begin
      wipe_table();
      frame_t0 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_backpressure();
      test_no_idle();
      test_random(300);
      drain_results();
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/nrp_pkg.sv
rtl/nrp_ram.sv
rtl/nrp_div.sv
rtl/nested_region_profiler_core.sv
dv/tb_nested_region_profiler_core.sv
